>>> rtl/mhfd_pkg.sv
// Package for the sync-word frame deframer.
// Holds the result word type, register indexes and field widths.
// No dependencies; compiled first.
package mhfd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    typedef logic [0:0] t_reg_idx;

    localparam t_reg_idx REG_FIRST_SYNC  = 1'b0;
    localparam t_reg_idx REG_SECOND_SYNC = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  frame_length;
        logic [LEN_W-1:0]  byte_index;
        logic              last_of_frame;
        logic              empty_frame;
    } t_result;

    typedef struct packed {
        logic              we;
        t_reg_idx          idx;
        logic [BYTE_W-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/mhfd_if.sv
// Valid/ready channel interfaces of the deframer.
// mhfd_rx_if carries received bytes, mhfd_frm_if carries result words.
// Depends on mhfd_pkg.
interface mhfd_rx_if;
    import mhfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mhfd_frm_if;
    import mhfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] frame_type;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  byte_index;
    logic              last_of_frame;
    logic              empty_frame;

    modport source (output valid, output payload_byte, output frame_type,
                    output frame_length, output byte_index, output last_of_frame,
                    output empty_frame, input ready);
    modport sink   (input valid, input payload_byte, input frame_type,
                    input frame_length, input byte_index, input last_of_frame,
                    input empty_frame, output ready);
endinterface

>>> rtl/mhfd_parser.sv
// Header parser of the deframer: sync registers, frame state and the
// per-byte decision that yields at most one result word per received byte.
// Depends on mhfd_pkg.
module mhfd_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mhfd_pkg::t_cfg_wr       i_cfg,
    input  logic                    i_take,
    input  logic [mhfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                    o_res_valid,
    output mhfd_pkg::t_result       o_res
);
    import mhfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase_e;

    t_phase_e          r_phase, n_phase;
    logic [BYTE_W-1:0] r_first_sync;
    logic [BYTE_W-1:0] r_second_sync;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_len_lo, n_len_lo;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_seen, n_seen;
    logic [LEN_W:0]    idx_next;
    logic [LEN_W-1:0]  len_full;
    logic              is_last;

    assign idx_next = {1'b0, r_seen} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last  = idx_next >= {1'b0, r_len};
    assign len_full = {i_rx_byte, r_len_lo};

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len_lo    = r_len_lo;
        n_len       = r_len;
        n_seen      = r_seen;
        o_res_valid = 1'b0;
        o_res.payload_byte  = '0;
        o_res.frame_type    = r_type;
        o_res.frame_length  = r_len;
        o_res.byte_index    = '0;
        o_res.last_of_frame = 1'b0;
        o_res.empty_frame   = 1'b0;
        unique case (r_phase)
            PH_HUNT2: begin
                n_phase = (i_rx_byte == r_second_sync) ? PH_TYPE : PH_HUNT1;
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len_lo = i_rx_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len  = len_full;
                n_seen = '0;
                if (len_full == '0) begin
                    n_phase             = PH_HUNT1;
                    o_res_valid         = 1'b1;
                    o_res.frame_length  = len_full;
                    o_res.last_of_frame = 1'b1;
                    o_res.empty_frame   = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_seen              = idx_next[LEN_W-1:0];
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_rx_byte;
                o_res.byte_index    = r_seen;
                o_res.last_of_frame = is_last;
                if (is_last) begin
                    n_phase = PH_HUNT1;
                end
            end
            default: begin
                n_phase = (i_rx_byte == r_first_sync) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT1;
            r_first_sync  <= '0;
            r_second_sync <= '0;
            r_type        <= '0;
            r_len_lo      <= '0;
            r_len         <= '0;
            r_seen        <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_FIRST_SYNC:  r_first_sync  <= i_cfg.data;
                    REG_SECOND_SYNC: r_second_sync <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_take) begin
                r_phase  <= n_phase;
                r_type   <= n_type;
                r_len_lo <= n_len_lo;
                r_len    <= n_len;
                r_seen   <= n_seen;
            end
        end
    end

endmodule

>>> rtl/mhfd_out_stage.sv
// Result register of the deframer: holds one result word until the sink
// takes it and refills in the same cycle. Depends on mhfd_pkg.
module mhfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  mhfd_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output mhfd_pkg::t_result o_res
);
    import mhfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/magic_header_frame_deframer_unit.sv
// Sync-word frame deframer: one received byte per clock cycle in, its result
// word, if any, registered in the output register. Ready falls only
// while that register holds a word the sink has not yet taken; the parser's
// single state update per byte sets the rate. Header bytes give no word, a
// zero-length frame gives one empty-frame word at its last header byte.
module magic_header_frame_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  mhfd_pkg::t_reg_idx          i_cfg_idx,
    input  logic [mhfd_pkg::BYTE_W-1:0] i_cfg_data,
    mhfd_rx_if.sink                     i_rx,
    mhfd_frm_if.source                  o_frm
);
    import mhfd_pkg::*;

    t_cfg_wr cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    free;
    logic    take;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign i_rx.ready = free;
    assign take       = i_rx.valid && free;

    mhfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_take      (take),
        .i_rx_byte   (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mhfd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (o_frm.ready),
        .o_free      (free),
        .o_valid     (o_frm.valid),
        .o_res       (out_res)
    );

    assign o_frm.payload_byte  = out_res.payload_byte;
    assign o_frm.frame_type    = out_res.frame_type;
    assign o_frm.frame_length  = out_res.frame_length;
    assign o_frm.byte_index    = out_res.byte_index;
    assign o_frm.last_of_frame = out_res.last_of_frame;
    assign o_frm.empty_frame   = out_res.empty_frame;

endmodule

>>> rtl/mhfd_chk.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on mhfd_pkg and the top-level ports.
module mhfd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rx_valid,
    input logic                        i_rx_ready,
    input logic                        i_frm_valid,
    input logic                        i_frm_ready,
    input logic [mhfd_pkg::BYTE_W-1:0] i_payload_byte,
    input logic [mhfd_pkg::LEN_W-1:0]  i_frame_length,
    input logic [mhfd_pkg::LEN_W-1:0]  i_byte_index,
    input logic                        i_last_of_frame,
    input logic                        i_empty_frame
);
    import mhfd_pkg::*;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_frm_valid)
        else $error("Result word valid right after reset.");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_ready |=> i_frm_valid)
        else $error("Result word dropped while stalled.");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_ready |-> !i_rx_ready)
        else $error("Input ready while result register is stalled.");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && i_empty_frame |-> i_last_of_frame && i_payload_byte == '0
            && i_byte_index == '0 && i_frame_length == '0)
        else $error("Malformed empty-frame word.");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && i_last_of_frame && !i_empty_frame
            |-> i_byte_index == i_frame_length - LEN_W'(1))
        else $error("Last payload word at wrong index.");

endmodule

bind magic_header_frame_deframer_unit mhfd_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx.valid),
    .i_rx_ready      (i_rx.ready),
    .i_frm_valid     (o_frm.valid),
    .i_frm_ready     (o_frm.ready),
    .i_payload_byte  (o_frm.payload_byte),
    .i_frame_length  (o_frm.frame_length),
    .i_byte_index    (o_frm.byte_index),
    .i_last_of_frame (o_frm.last_of_frame),
    .i_empty_frame   (o_frm.empty_frame)
);
